// ===== rtl/core/uirf_pkg.sv =====
// ============================================================================
// uirf_pkg
// Types, constants and status codes shared by the UDP/IPv4 receive filter.
// ============================================================================
package uirf_pkg;

  localparam int unsigned MaxFrameBytesDefault = 2048;
  localparam int unsigned CntW = 17;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW = 2;

  localparam logic [3:0] IhlMask = 4'hf;
  localparam logic [31:0] IpBcast = 32'hFFFFFFFF;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_ETH_SHORT = 4'd1,
    ST_MAC_MISS  = 4'd2,
    ST_NOT_IPV4  = 4'd3,
    ST_IP_SHORT  = 4'd4,
    ST_IP_LEN    = 4'd5,
    ST_CHECKSUM  = 4'd6,
    ST_IP_MISS   = 4'd7,
    ST_NOT_UDP   = 4'd8,
    ST_UDP_SHORT = 4'd9,
    ST_UDP_LEN   = 4'd10,
    ST_TOO_LONG  = 4'd11
  } status_e;

  typedef enum logic {
    REG_OUR_MAC = 1'b0,
    REG_OUR_IP  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [3:0]  status;
    logic [15:0] udp_dport;
    logic [10:0] pay_len;
    logic        to_broadcast;
    logic        last;
  } out_item_t;

  // classified byte handed from the front to the back
  typedef struct packed {
    logic [7:0]      frame_byte;
    logic            eof;
    logic            parse;
    logic [CntW-1:0] pos;
    logic            is_payload;
  } cls_item_t;

endpackage

// ===== rtl/core/uirf_front.sv =====
// ============================================================================
// uirf_front
// Accepts frame bytes, tracks the byte position and IHL, tags payload bytes.
// ============================================================================
module uirf_front
  import uirf_pkg::*;
#(
  parameter int unsigned MaxFrameBytes = MaxFrameBytesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_item_i,
  output logic      in_ready_o,
  output logic      cls_valid_o,
  output cls_item_t cls_item_o,
  input  logic      cls_ready_i
);

  localparam logic [CntW-1:0] MaxB = CntW'(MaxFrameBytes);

  logic [CntW-1:0] pos_q, pos_d;
  logic [3:0]      ihl_q, ihl_d;
  logic [CntW-1:0] udp_start;
  logic            parse;
  logic            fire;

  assign in_ready_o  = cls_ready_i;
  assign cls_valid_o = in_valid_i;
  assign fire        = in_valid_i && cls_ready_i;
  assign parse       = pos_q < MaxB;

  always_comb begin
    logic [3:0] ihl_eff;
    ihl_eff = (pos_q == CntW'(14)) ? (in_item_i.frame_byte[3:0] & IhlMask) : ihl_q;
    udp_start = (ihl_eff < 4'd5) ? CntW'(34) : CntW'(14) + CntW'({ihl_eff, 2'b00});
  end

  always_comb begin
    cls_item_o.frame_byte = in_item_i.frame_byte;
    cls_item_o.eof        = in_item_i.end_of_frame;
    cls_item_o.parse      = parse;
    cls_item_o.pos        = pos_q;
    cls_item_o.is_payload = parse && pos_q >= CntW'(14) && pos_q >= udp_start + CntW'(8);
  end

  always_comb begin
    pos_d = pos_q;
    ihl_d = ihl_q;
    if (fire) begin
      if (parse && pos_q == CntW'(14)) ihl_d = in_item_i.frame_byte[3:0];
      if (pos_q <= MaxB) pos_d = pos_q + CntW'(1);
      if (in_item_i.end_of_frame) begin
        pos_d = '0;
        ihl_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ihl_q <= '0;
    end else begin
      pos_q <= pos_d;
      ihl_q <= ihl_d;
    end
  end

endmodule

// ===== rtl/core/uirf_queue.sv =====
// ============================================================================
// uirf_queue
// Small FIFO between the front and the back.
// ============================================================================
module uirf_queue
  import uirf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  input  cls_item_t wr_item_i,
  output logic      wr_ready_o,
  output logic      rd_valid_o,
  output cls_item_t rd_item_o,
  input  logic      rd_ready_i
);

  cls_item_t       mem_q [QueueDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QPtrW:0]   cnt_q;
  logic             wr, rd;

  assign wr_ready_o = cnt_q != (QPtrW+1)'(QueueDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_item_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + QPtrW'(1);
      if (rd) rp_q <= rp_q + QPtrW'(1);
      cnt_q <= cnt_q + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
    end
  end

endmodule

// ===== rtl/core/uirf_back.sv =====
// ============================================================================
// uirf_back
// Header checks and result generation; emits payload and verdict items.
// ============================================================================
module uirf_back
  import uirf_pkg::*;
#(
  parameter int unsigned MaxFrameBytes = MaxFrameBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [47:0] our_mac_i,
  input  logic [31:0] our_ip_i,
  input  logic        cls_valid_i,
  input  cls_item_t   cls_item_i,
  output logic        cls_ready_o,
  output logic        empty_o,
  output out_item_t   out_item_o,
  input  logic        pop_i
);

  localparam logic [CntW-1:0] MaxB = CntW'(MaxFrameBytes);

  // per-frame state
  logic        mac_ok_q, mcast_q, eth_ip_q, udp_q;
  logic [31:0] shift_q;
  logic [3:0]  ihl_q;
  logic [15:0] tot_q, port_q, ulen_q;
  logic [16:0] csum_q;
  logic [1:0]  dflags_q;
  logic [10:0] pcnt_q;

  // output pair: verdict waits behind a payload item when both arise
  out_item_t o0_q, o1_q;
  logic      v0_q, v1_q;

  cls_item_t       c;
  logic            take;
  logic [31:0]     sh;
  logic [CntW-1:0] p, len, l2, l3, hb, ustart;
  logic [3:0]      ihl_n;
  logic [16:0]     s;
  logic [7:0]      want;
  logic [3:0]      st;
  logic [10:0]     pcnt_n;
  logic            mac_ok_n;

  assign c = cls_item_i;
  assign p = c.pos;
  assign cls_ready_o = !v1_q && (!v0_q || pop_i);
  assign take = cls_valid_i && cls_ready_o;
  assign sh = {shift_q[23:0], c.frame_byte};
  assign ihl_n = (c.parse && p == CntW'(14)) ? c.frame_byte[3:0] : ihl_q;
  assign hb = (ihl_n < 4'd5) ? CntW'(20) : CntW'({ihl_n, 2'b00});
  assign ustart = CntW'(14) + hb;
  assign s = csum_q + {1'b0, sh[15:0]};
  assign want = our_mac_i[8*(5 - ((p < CntW'(6)) ? p[2:0] : 3'd0)) +: 8];
  assign mac_ok_n = mac_ok_q && !(c.parse && p < CntW'(6) && c.frame_byte != want);
  assign pcnt_n = (c.is_payload && pcnt_q != 11'd2047) ? pcnt_q + 11'd1 : pcnt_q;
  assign len = (p <= MaxB) ? p + CntW'(1) : p;
  assign l2 = len - CntW'(14);
  assign l3 = l2 - CntW'({ihl_n, 2'b00});

  logic eth_ip_n, udp_n, mcast_n;
  logic [16:0] csum_n;
  logic [15:0] tot_n, port_n, ulen_n;
  logic [1:0]  dflags_n;

  always_comb begin
    eth_ip_n = eth_ip_q;
    udp_n    = udp_q;
    mcast_n  = mcast_q;
    csum_n   = csum_q;
    tot_n    = tot_q;
    port_n   = port_q;
    ulen_n   = ulen_q;
    dflags_n = dflags_q;
    if (c.parse) begin
      if (p == CntW'(0)) mcast_n = c.frame_byte[0];
      if (p == CntW'(13) && sh[15:0] == 16'h0800) eth_ip_n = 1'b1;
      if (p >= CntW'(14) && p < CntW'(14) + CntW'({ihl_n, 2'b00}) && p[0])
        csum_n = {1'b0, s[15:0]} + {16'd0, s[16]};
      if (p == CntW'(17)) tot_n = sh[15:0];
      if (p == CntW'(23) && c.frame_byte == 8'd17) udp_n = 1'b1;
      if (p == CntW'(33)) dflags_n = {sh == IpBcast, sh == our_ip_i};
      if (p >= CntW'(14) && p == ustart + CntW'(3)) port_n = sh[15:0];
      if (p >= CntW'(14) && p == ustart + CntW'(5)) ulen_n = sh[15:0];
    end
  end

  always_comb begin
    if (len > MaxB) st = ST_TOO_LONG;
    else if (len < CntW'(14)) st = ST_ETH_SHORT;
    else if (!mcast_n && !mac_ok_n) st = ST_MAC_MISS;
    else if (!eth_ip_n) st = ST_NOT_IPV4;
    else if (l2 < CntW'(20) || ihl_n < 4'd5 || l2 < CntW'({ihl_n, 2'b00})) st = ST_IP_SHORT;
    else if (l2 != CntW'(tot_n)) st = ST_IP_LEN;
    else if (csum_n != 17'h0FFFF) st = ST_CHECKSUM;
    else if (dflags_n == 2'b00) st = ST_IP_MISS;
    else if (!udp_n) st = ST_NOT_UDP;
    else if (l3 < CntW'(8)) st = ST_UDP_SHORT;
    else if (CntW'(ulen_n) != l3) st = ST_UDP_LEN;
    else st = ST_OK;
  end

  out_item_t pay, ver;
  always_comb begin
    pay = '0;
    pay.payload_byte = c.frame_byte;
    pay.last = !c.eof;
    ver = '0;
    ver.kind = 1'b1;
    ver.status = st;
    ver.udp_dport = port_n;
    ver.pay_len = pcnt_n;
    ver.to_broadcast = dflags_n[1];
    ver.last = 1'b1;
  end

  assign empty_o = !v0_q;
  assign out_item_o = o0_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (c.is_payload) begin
        o0_q <= pay;
        o1_q <= ver;
      end else begin
        o0_q <= ver;
      end
    end else if (v0_q && pop_i) begin
      o0_q <= o1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (take) begin
      v0_q <= c.is_payload || c.eof;
      v1_q <= c.is_payload && c.eof;
    end else if (v0_q && pop_i) begin
      v0_q <= v1_q;
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_ok_q <= 1'b1;
      mcast_q  <= 1'b0;
      eth_ip_q <= 1'b0;
      udp_q    <= 1'b0;
      shift_q  <= '0;
      ihl_q    <= '0;
      tot_q    <= '0;
      port_q   <= '0;
      ulen_q   <= '0;
      csum_q   <= '0;
      dflags_q <= '0;
      pcnt_q   <= '0;
    end else if (take) begin
      if (c.eof) begin
        mac_ok_q <= 1'b1;
        mcast_q  <= 1'b0;
        eth_ip_q <= 1'b0;
        udp_q    <= 1'b0;
        shift_q  <= '0;
        ihl_q    <= '0;
        tot_q    <= '0;
        port_q   <= '0;
        ulen_q   <= '0;
        csum_q   <= '0;
        dflags_q <= '0;
        pcnt_q   <= '0;
      end else begin
        mac_ok_q <= mac_ok_n;
        mcast_q  <= mcast_n;
        eth_ip_q <= eth_ip_n;
        udp_q    <= udp_n;
        if (c.parse) shift_q <= sh;
        ihl_q    <= ihl_n;
        tot_q    <= tot_n;
        port_q   <= port_n;
        ulen_q   <= ulen_n;
        csum_q   <= csum_n;
        dflags_q <= dflags_n;
        pcnt_q   <= pcnt_n;
      end
    end
  end

endmodule

// ===== rtl/core/udp_ipv4_receive_filter_core.sv =====
// ============================================================================
// udp_ipv4_receive_filter_core
// Streaming Ethernet/IPv4/UDP receive filter.
// ============================================================================
// Input channel: push with frame bytes in wire order, end_of_frame on the
// final byte; an item is taken when push is high and full low.
// Result channel: while empty is low the oldest result is on out_item_o;
// pop takes it. Payload bytes come out tentatively, one item each; the
// final byte of a frame yields a verdict item (after its payload item, if
// any) carrying status, port, payload length and broadcast mark.
// Throughput is one byte per cycle while results are popped; a byte that
// yields two results holds the back end until its payload item is popped,
// absorbed by the four-entry queue. With the queue empty, a taken byte is
// written to the queue, then its result is registered on the ports.
// Configuration (our_mac index 0, our_ip index 1) is written over
// cfg_valid_i/cfg_ready_o, always ready; write only while idle.
// Reset empties the queue and the result register and clears all per-frame
// state and the address registers. When pop is held low, the results
// stay put, the queue fills and full then rises.
module udp_ipv4_receive_filter_core
  import uirf_pkg::*;
#(
  parameter int unsigned MaxFrameBytes = MaxFrameBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  logic [47:0] our_mac_q;
  logic [31:0] our_ip_q;
  logic        f_valid, f_ready, b_valid, b_ready;
  logic        f_ready_q;
  cls_item_t   f_item, b_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      our_mac_q <= '0;
      our_ip_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_OUR_MAC: our_mac_q <= cfg_data_i;
        REG_OUR_IP:  our_ip_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  uirf_front #(.MaxFrameBytes(MaxFrameBytes)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(push), .in_item_i, .in_ready_o(f_ready),
    .cls_valid_o(f_valid), .cls_item_o(f_item), .cls_ready_i(f_ready_q)
  );

  assign full = !f_ready;

  uirf_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_item_i(f_item), .wr_ready_o(f_ready_q),
    .rd_valid_o(b_valid), .rd_item_o(b_item), .rd_ready_i(b_ready)
  );

  uirf_back #(.MaxFrameBytes(MaxFrameBytes)) u_back (
    .clk_i, .rst_ni,
    .our_mac_i(our_mac_q), .our_ip_i(our_ip_q),
    .cls_valid_i(b_valid), .cls_item_i(b_item), .cls_ready_o(b_ready),
    .empty_o(empty), .out_item_o, .pop_i(pop)
  );

endmodule

// ===== rtl/core/uirf_checker.sv =====
// ============================================================================
// uirf_checker
// Port-level checks on the receive filter, bound to the top level.
// ============================================================================
module uirf_checker
  import uirf_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("result changed while stalled");

  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.kind |-> out_item_o.last && out_item_o.payload_byte == 8'd0)
    else $error("verdict item malformed");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_item_o.kind |-> out_item_o.status == ST_OK && out_item_o.udp_dport == 16'd0)
    else $error("payload item malformed");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.kind |-> out_item_o.status <= ST_TOO_LONG)
    else $error("status out of range");

endmodule

bind udp_ipv4_receive_filter_core uirf_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .out_item_o
);
